FILE: design/bmrb_pkg.sv
// Shared types, constants and helper functions of the board register block.
`timescale 1ns / 1ps
package bmrb_pkg;

  // Register map.
  localparam int              FILE_REGS       = 18;
  localparam int              SEMAPHORE_SLOTS = 16;
  localparam logic [15:0]     SEMAPHORE_BASE  = 16'd176;
  localparam logic [16:0]     CONTROL_OFFSET  = 17'd4096;
  localparam logic [16:0]     SCRATCH1_OFFSET = 17'd4120;
  localparam logic [16:0]     MISC_OFFSET     = 17'd4128;
  localparam logic [16:0]     LAYOUT_OFFSET   = 17'h01010;
  localparam logic [15:0]     PRES_OFFSET     = 16'h0000;
  localparam logic [15:0]     POST_OFFSET     = 16'h0018;
  localparam logic [16:0]     FILE_BYTES      = 17'(8 * FILE_REGS);
  localparam int              MAX_SOCKETS     = 4;

  // Field widths.
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 4;
  localparam int DATA_W   = 64;
  localparam int SOCK_W   = 3;
  localparam int SEM_ID_W = 7;

  // Backing memory: the scratch file, then control, scratch1 and misc.
  localparam int                MEM_DEPTH = FILE_REGS + 3;
  localparam int                MEM_AW    = $clog2(MEM_DEPTH);
  localparam logic [MEM_AW-1:0] CTRL_IDX  = MEM_AW'(FILE_REGS);
  localparam logic [MEM_AW-1:0] SCR1_IDX  = MEM_AW'(FILE_REGS + 1);
  localparam logic [MEM_AW-1:0] MISC_IDX  = MEM_AW'(FILE_REGS + 2);

  // What an access targets.
  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_PRES,
    TGT_POST,
    TGT_MEM,
    TGT_SEM,
    TGT_LAYOUT
  } tgt_e;

  // Decoded access, held for the whole execution of one item.
  typedef struct packed {
    tgt_e                tgt;
    logic                wr;
    logic                is_ctrl;
    logic [MEM_AW-1:0]   mem_idx;
    logic [2:0]          shift;
    logic [DATA_W-1:0]   mask;
    logic [DATA_W-1:0]   wdata;
    logic [SEM_ID_W-1:0] sem_id;
  } dec_t;

  // One write of the backing memory.
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // Byte-lane mask for an access of the given size.
  function automatic logic [DATA_W-1:0] lane_mask(logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[8*i +: 8] = (SIZE_W'(i) < size) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  // True if the access lies inside the 8 bytes at base.
  function automatic logic inside8(logic [OFFSET_W-1:0] a, logic [16:0] sum,
                                   logic [16:0] base);
    return ({1'b0, a} >= base) && (sum <= base + 17'd8);
  endfunction

endpackage

FILE: design/bmrb_if.sv
// Handshake channels of the board register block: access, result and configuration.
`timescale 1ns / 1ps

// Access channel.
interface bmrb_req_if import bmrb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic                block;
  logic [OFFSET_W-1:0] offset;
  logic [SIZE_W-1:0]   access_size;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, command, block, offset, access_size, write_data,
                  input ready);
  modport sink   (input valid, command, block, offset, access_size, write_data,
                  output ready);
endinterface

// Result channel.
interface bmrb_rsp_if import bmrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              decoded;
  logic              reset_request;

  modport source (output valid, read_data, decoded, reset_request, input ready);
  modport sink   (input valid, read_data, decoded, reset_request, output ready);
endinterface

// Configuration write channel.
interface bmrb_cfg_if import bmrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SOCK_W-1:0] socket_count;

  modport source (output valid, socket_count, input ready);
  modport sink   (input valid, socket_count, output ready);
endinterface

FILE: design/bmrb_decode.sv
// Address decoder: maps one access onto its target register and byte lanes.
`timescale 1ns / 1ps
module bmrb_decode import bmrb_pkg::*; (
  input  logic                command_i,
  input  logic                block_i,
  input  logic [OFFSET_W-1:0] offset_i,
  input  logic [SIZE_W-1:0]   access_size_i,
  input  logic [DATA_W-1:0]   write_data_i,
  output dec_t                dec_o
);

  logic              size_ok;
  logic [16:0]       sum;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] wdata;
  logic              file_hit;
  logic              sem_hit;
  logic [15:0]       sem_off;
  logic              ctrl_hit;
  logic              scr1_hit;
  logic              misc_hit;
  logic              layout_hit;

  // Range checks shared by reads and writes.
  assign size_ok  = (access_size_i >= 4'd1) && (access_size_i <= 4'd8);
  assign sum      = {1'b0, offset_i} + 17'(access_size_i);
  assign mask     = lane_mask(access_size_i);
  assign wdata    = write_data_i & mask;
  assign file_hit = (sum <= FILE_BYTES) &&
                    ((4'({1'b0, offset_i[2:0]}) + access_size_i) <= 4'd8);
  assign sem_off  = offset_i - SEMAPHORE_BASE;
  assign sem_hit  = (access_size_i == 4'd1) && (offset_i >= SEMAPHORE_BASE) &&
                    (sem_off[2:0] == 3'd0) &&
                    (sem_off[15:3] < 13'(SEMAPHORE_SLOTS));
  assign ctrl_hit   = inside8(offset_i, sum, CONTROL_OFFSET);
  assign scr1_hit   = inside8(offset_i, sum, SCRATCH1_OFFSET);
  assign misc_hit   = inside8(offset_i, sum, MISC_OFFSET);
  assign layout_hit = inside8(offset_i, sum, LAYOUT_OFFSET);

  // Target selection in the priority order of the register map.
  always_comb begin
    dec_o         = '0;
    dec_o.tgt     = TGT_NONE;
    dec_o.wr      = command_i;
    dec_o.mask    = mask;
    dec_o.wdata   = wdata;
    dec_o.sem_id  = sem_off[SEM_ID_W+2:3];
    if (size_ok) begin
      if (!block_i) begin
        if (!command_i && offset_i == PRES_OFFSET && access_size_i == 4'd1) begin
          dec_o.tgt = TGT_PRES;
        end else if (offset_i == POST_OFFSET && access_size_i == 4'd1) begin
          dec_o.tgt = TGT_POST;
        end
      end else if (file_hit) begin
        dec_o.tgt     = TGT_MEM;
        dec_o.mem_idx = offset_i[MEM_AW+2:3];
        dec_o.shift   = offset_i[2:0];
      end else if (!command_i && sem_hit) begin
        dec_o.tgt = TGT_SEM;
      end else if (ctrl_hit) begin
        dec_o.tgt     = TGT_MEM;
        dec_o.is_ctrl = 1'b1;
        dec_o.mem_idx = CTRL_IDX;
        dec_o.shift   = offset_i[2:0] - CONTROL_OFFSET[2:0];
      end else if (scr1_hit) begin
        dec_o.tgt     = TGT_MEM;
        dec_o.mem_idx = SCR1_IDX;
        dec_o.shift   = offset_i[2:0] - SCRATCH1_OFFSET[2:0];
      end else if (misc_hit) begin
        dec_o.tgt     = TGT_MEM;
        dec_o.mem_idx = MISC_IDX;
        dec_o.shift   = offset_i[2:0] - MISC_OFFSET[2:0];
      end else if (!command_i && layout_hit) begin
        dec_o.tgt = TGT_LAYOUT;
      end else if (command_i && sem_hit && wdata == '0) begin
        // Only a zero write to a semaphore slot is a release.
        dec_o.tgt = TGT_SEM;
      end
    end
  end

endmodule

FILE: design/bmrb_regfile.sv
// Backing memory for the scratch file and the 64-bit registers, with reset valid bits.
`timescale 1ns / 1ps
module bmrb_regfile import bmrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [MEM_AW-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  input  mem_wr_t           wr_i
);

  logic [DATA_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [DATA_W-1:0]    rdata_q;

  // Valid bits: an entry never written reads as its reset value, zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Storage array with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/board_misc_register_block_top.sv
// Top level of the board register block: item sequencing, small registers and result stage.
`timescale 1ns / 1ps
// Board register block.
// The access channel (req) takes one bus access per item: command, block,
// offset, access size and write data. The result channel (rsp) returns one
// item per access with read data, a decoded flag and a reset request flag.
// The configuration channel (cfg) writes the socket count; it is always
// ready and should be written only while no access is in flight.
// Each access runs in a decode step and an execute step: in the cycle it
// is accepted the decoder selects a word and the backing memory is read;
// in the execute step, once the output register is free, the word is merged
// by byte lanes, written back and the result is loaded into the output
// register. The next access is not read until this write-back is done,
// so a new access is taken only after the previous one has completed.
// A new access may be accepted while the previous result still waits in
// the output register. If the receiver stalls, the second access waits in
// its execute step until the output register frees up.
// Reset clears the semaphore, the POST byte and the valid bits of the
// backing memory, so every memory word reads zero, and sets the socket count
// to one. No clearing pass is needed after reset.
module board_misc_register_block_top import bmrb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  bmrb_req_if.sink   req,
  bmrb_rsp_if.source rsp,
  bmrb_cfg_if.sink   cfg
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q, state_d;
  dec_t              dec;
  dec_t              dec_q;
  logic              accept;
  logic              finish;
  logic [DATA_W-1:0] rdata;
  mem_wr_t           mem_wr;

  logic [SOCK_W-1:0] socket_q;
  logic [7:0]        post_q;
  logic [7:0]        sem_q;

  logic              rsp_valid_q;
  logic [DATA_W-1:0] rsp_data_q;
  logic              rsp_dec_q;
  logic              rsp_rst_q;

  logic [5:0]        shamt;
  logic [DATA_W-1:0] lane_m;
  logic [DATA_W-1:0] merged;
  logic [DATA_W-1:0] rd;
  logic [2:0]        sock_n;
  logic [7:0]        pres_byte;

  // Decode of the incoming access.
  bmrb_decode u_decode (
    .command_i     (req.command),
    .block_i       (req.block),
    .offset_i      (req.offset),
    .access_size_i (req.access_size),
    .write_data_i  (req.write_data),
    .dec_o         (dec)
  );

  // Backing memory, read on accept and written back when the item completes.
  bmrb_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (dec.mem_idx),
    .rdata_o (rdata),
    .wr_i    (mem_wr)
  );

  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign finish    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);
  assign cfg.ready = 1'b1;

  // Byte-lane merge and extract of the word read from memory.
  assign shamt  = {dec_q.shift, 3'b000};
  assign lane_m = dec_q.mask << shamt;
  assign merged = (rdata & ~lane_m) | ((dec_q.wdata << shamt) & lane_m);

  // Presence byte: the populated sockets read as zero bits.
  assign sock_n = (socket_q > 3'(MAX_SOCKETS)) ? 3'(MAX_SOCKETS) : socket_q;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pres_byte[i] = !(3'(i) < sock_n);
    end
  end

  // Read data of the item in execution.
  always_comb begin
    case (dec_q.tgt)
      TGT_PRES: rd = DATA_W'(pres_byte);
      TGT_POST: rd = DATA_W'(post_q);
      TGT_MEM:  rd = (rdata >> shamt) & dec_q.mask;
      TGT_SEM:  rd = sem_q[0] ? DATA_W'(sem_q) : '0;
      default:  rd = '0;
    endcase
  end

  // Write back of a memory word.
  always_comb begin
    mem_wr.we   = finish && dec_q.wr && (dec_q.tgt == TGT_MEM);
    mem_wr.addr = dec_q.mem_idx;
    mem_wr.data = merged;
  end

  // Sequencer with the held item and the result register.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= '0;
      rsp_dec_q   <= 1'b0;
      rsp_rst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        rsp_valid_q <= 1'b1;
        rsp_data_q  <= dec_q.wr ? '0 : rd;
        rsp_dec_q   <= (dec_q.tgt != TGT_NONE);
        rsp_rst_q   <= dec_q.wr && dec_q.is_ctrl && merged[0];
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Held decode of the accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= dec;
    end
  end

  // Socket count, POST byte and semaphore.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      socket_q <= SOCK_W'(1);
      post_q   <= '0;
      sem_q    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        socket_q <= cfg.socket_count;
      end
      if (finish && dec_q.tgt == TGT_POST && dec_q.wr) begin
        post_q <= dec_q.wdata[7:0];
      end
      if (finish && dec_q.tgt == TGT_SEM) begin
        if (!dec_q.wr && !sem_q[0]) begin
          sem_q <= {dec_q.sem_id, 1'b1};
        end else if (dec_q.wr && sem_q[0] && sem_q[7:1] == dec_q.sem_id) begin
          sem_q <= '0;
        end
      end
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.read_data     = rsp_data_q;
  assign rsp.decoded       = rsp_dec_q;
  assign rsp.reset_request = rsp_rst_q;

  // An accepted item always moves into its execute step.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted item did not enter execution");

  // Memory is written only when an item completes.
  a_wr_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.we |-> (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready))
    else $error("memory written outside item completion");

  // A reset request only comes with a decoded access.
  a_rst_decoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_rst_q |-> rsp_dec_q)
    else $error("reset request on an undecoded access");

  // The semaphore changes only at the completion of an item.
  a_sem_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sem_q) |-> $past(finish))
    else $error("semaphore changed outside item completion");

endmodule
